[rtl/bb3_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package bb3_pkg;

  // Default line store depth (pixels per row).
  localparam int MAX_WIDTH_DEFAULT = 4096;
  localparam int MAX_HEIGHT        = 4096;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam int FRAME_WIDTH_RESET  = 640;
  localparam int FRAME_HEIGHT_RESET = 480;

  // Request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Pixel and sum widths
  localparam int CHAN_W = 8;
  localparam int NCHAN  = 3;
  localparam int PIX_W  = NCHAN * CHAN_W;
  localparam int COL_W  = 10;  // sum of three channel values
  localparam int SUM_W  = 12;  // sum of nine channel values

  // Divide by 9: floor(x * 3641 / 2^15) is exact for x < 32768
  localparam int DIV9_MUL   = 3641;
  localparam int DIV9_SHIFT = 15;

  typedef struct packed {
    logic       req_type;
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } req_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       frame_done;
  } rsp_t;

  function automatic logic [CHAN_W-1:0] div9(input logic [SUM_W-1:0] x);
    logic [2*SUM_W-1:0] prod;
    prod = (2*SUM_W)'(x) * (2*SUM_W)'(DIV9_MUL);
    return prod[DIV9_SHIFT +: CHAN_W];
  endfunction

endpackage

`default_nettype wire

[rtl/bb3_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module bb3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/box_blur_3x3_rgb.sv]
`timescale 1ns / 1ps
`default_nettype none

// Path: a result is presented in the output register after the stage 1, stage 2 and output registers following the
//   transfer of the item that completes its window; that item lies one row plus one pixel behind.
// Throughput: one item per cycle while the output is not stalled; the line store has one read and one write port.
// Reset: counters and valid flags clear, frame_width 640 (clamped to MAX_WIDTH) and frame_height 480;
//   line store contents are left as they are, and data read from them before being written is masked.
module box_blur_3x3_rgb #(
  parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEFAULT
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input items
  input  wire logic                            req_valid,
  output logic                                 req_ready,
  input  wire bb3_pkg::req_t                   req,
  // results
  output logic                                 rsp_valid,
  input  wire logic                            rsp_ready,
  output bb3_pkg::rsp_t                        rsp,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [bb3_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);        // column index width
  localparam int WCW   = $clog2(MAX_WIDTH + 1);    // width value width
  localparam int CMPW  = (WCW > bb3_pkg::CFG_DATA_W) ? WCW : bb3_pkg::CFG_DATA_W;
  localparam int HW    = bb3_pkg::CFG_DATA_W;      // row counter / height width
  localparam int PW    = bb3_pkg::PIX_W;
  localparam int NC    = bb3_pkg::NCHAN;
  localparam int W_RST = (bb3_pkg::FRAME_WIDTH_RESET > MAX_WIDTH) ?
                         MAX_WIDTH : bb3_pkg::FRAME_WIDTH_RESET;

  // ---------------------------------------------------------------------------
  // Configuration: hold the clamped width and height, restart the frame on any
  // write to a known register.
  // ---------------------------------------------------------------------------
  logic [WCW-1:0] width;
  logic [HW-1:0]  height;
  logic [WCW-1:0] width_next;
  logic [HW-1:0]  height_next;
  logic           cfg_restart;

  always_comb begin
    if (cfg_wdata < bb3_pkg::CFG_DATA_W'(2)) begin
      width_next = WCW'(2);
    end else if (CMPW'(cfg_wdata) > CMPW'(MAX_WIDTH)) begin
      width_next = WCW'(MAX_WIDTH);
    end else begin
      width_next = WCW'(cfg_wdata);
    end
    if (cfg_wdata < HW'(2)) begin
      height_next = HW'(2);
    end else if (cfg_wdata > HW'(bb3_pkg::MAX_HEIGHT)) begin
      height_next = HW'(bb3_pkg::MAX_HEIGHT);
    end else begin
      height_next = cfg_wdata;
    end
  end

  assign cfg_restart = cfg_we && (cfg_addr == bb3_pkg::REG_FRAME_WIDTH ||
                                  cfg_addr == bb3_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      width  <= WCW'(W_RST);
      height <= HW'(bb3_pkg::FRAME_HEIGHT_RESET);
    end else if (cfg_we) begin
      if (cfg_addr == bb3_pkg::REG_FRAME_WIDTH) begin
        width <= width_next;
      end
      if (cfg_addr == bb3_pkg::REG_FRAME_HEIGHT) begin
        height <= height_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake. Each stage loads when empty or when its item moves on,
  // so a waiting result does not block items behind it while there is room.
  // ---------------------------------------------------------------------------
  logic s1_valid;
  logic s2_valid;
  logic out_load;
  logic s2_load_ok;
  logic s1_move;
  logic accept;

  assign out_load   = !rsp_valid || rsp_ready;
  assign s2_load_ok = !s2_valid || out_load;
  assign s1_move    = s1_valid && s2_load_ok;
  assign req_ready  = !s1_valid || s2_load_ok;
  assign accept     = req_valid && req_ready;

  // ---------------------------------------------------------------------------
  // Stage A: raster position, request filtering, line store read.
  // ---------------------------------------------------------------------------
  logic [CW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic          pixel_phase;
  logic          take;
  logic          last_col;
  logic          frame_end;

  assign pixel_phase = in_row < height;
  // Drop a flush during the pixel phase and a pixel during the drain.
  assign take      = accept && (pixel_phase ? (req.req_type == bb3_pkg::REQ_PIXEL)
                                            : (req.req_type == bb3_pkg::REQ_FLUSH));
  assign last_col  = (WCW'(in_col) + WCW'(1)) >= width;
  // The final flush sits on the second row past the image and closes the frame.
  assign frame_end = in_row == (height + HW'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_restart) begin
      in_col <= '0;
      in_row <= '0;
    end else if (take) begin
      if (frame_end) begin
        in_col <= '0;
        in_row <= '0;
      end else if (last_col) begin
        in_col <= '0;
        in_row <= in_row + HW'(1);
      end else begin
        in_col <= in_col + CW'(1);
      end
    end
  end

  // Stage 1 registers: item waiting for its line store read data.
  logic [CW-1:0] s1_col;
  logic          s1_col0;
  logic          s1_ge1;
  logic          s1_ge2;
  logic          s1_done;
  logic [PW-1:0] s1_pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_col  <= in_col;
      s1_col0 <= in_col == '0;
      s1_ge1  <= in_row != '0;
      s1_ge2  <= in_row > HW'(1);
      s1_done <= frame_end;
      s1_pix  <= pixel_phase ? {req.red_in, req.green_in, req.blue_in} : '0;
    end
  end

  // Line store: upper row in the top half, middle row in the bottom half of each
  // word. An entry is written when its item leaves stage 1; the next read of the
  // same entry comes a full row later. The one exception is the first pixel of a
  // new frame, which may read entry zero while the closing flush writes it; that
  // read sits on row zero and its data is masked.
  logic [2*PW-1:0] ram_rdata;
  logic [2*PW-1:0] ram_wdata;

  bb3_ram #(
    .WIDTH (2 * PW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_move),
    .waddr (s1_col),
    .wdata (ram_wdata),
    .re    (take),
    .raddr (in_col),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage B: rotate the rows, advance the window as column sums, form totals.
  // ---------------------------------------------------------------------------
  logic [NC-1:0][bb3_pkg::CHAN_W-1:0] up_px;
  logic [NC-1:0][bb3_pkg::CHAN_W-1:0] mid_px;
  logic [NC-1:0][bb3_pkg::CHAN_W-1:0] new_px;
  logic [NC-1:0][bb3_pkg::COL_W-1:0]  col_new;
  logic [NC-1:0][bb3_pkg::COL_W-1:0]  col_a;   // older of the two kept columns
  logic [NC-1:0][bb3_pkg::COL_W-1:0]  col_b;   // newer of the two kept columns
  logic [NC-1:0][bb3_pkg::SUM_W-1:0]  sum_b;
  logic                               s1_emit;

  assign up_px     = s1_ge2 ? ram_rdata[2*PW-1:PW] : '0;
  assign mid_px    = s1_ge1 ? ram_rdata[PW-1:0]    : '0;
  assign new_px    = s1_pix;
  assign ram_wdata = {mid_px, s1_pix};
  // On the first column the window closes the previous row with a zero column.
  assign s1_emit   = s1_col0 ? s1_ge2 : s1_ge1;

  always_comb begin
    for (int k = 0; k < NC; k++) begin
      col_new[k] = bb3_pkg::COL_W'(up_px[k]) + bb3_pkg::COL_W'(mid_px[k]) +
                   bb3_pkg::COL_W'(new_px[k]);
      sum_b[k]   = bb3_pkg::SUM_W'(col_a[k]) + bb3_pkg::SUM_W'(col_b[k]) +
                   (s1_col0 ? '0 : bb3_pkg::SUM_W'(col_new[k]));
    end
  end

  // Window: start afresh on the first column with only the new column present.
  always_ff @(posedge clk) begin
    if (s1_move) begin
      col_a <= s1_col0 ? '0 : col_b;
      col_b <= col_new;
    end
  end

  logic [NC-1:0][bb3_pkg::SUM_W-1:0] s2_sum;
  logic                              s2_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load_ok) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_sum  <= sum_b;
      s2_done <= s1_done;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage C: divide by nine into the output register.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s2_valid) begin
      rsp.red_out    <= bb3_pkg::div9(s2_sum[2]);
      rsp.green_out  <= bb3_pkg::div9(s2_sum[1]);
      rsp.blue_out   <= bb3_pkg::div9(s2_sum[0]);
      rsp.frame_done <= s2_done;
    end
  end

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  // Within a frame, read and write of the line store never hit the same entry
  // in one cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s1_move && take && !s1_done) |-> (s1_col != in_col))
    else $error("line store read and write collide");

  // The raster column stays inside the row.
  assert property (@(posedge clk) disable iff (rst)
    WCW'(in_col) < width)
    else $error("input column beyond frame width");

  // A blocked stage-1 item keeps its place and its column.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s2_load_ok) |=> (s1_valid && $stable(s1_col)))
    else $error("stage 1 item lost while blocked");

  // Only a first-column item on a drain row can close the frame.
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_done) |-> (s1_col0 && s1_ge2))
    else $error("frame end on wrong position");

endmodule

`default_nettype wire
